@@ hw/rtl/strpg_pkg.sv @@
// Shared types, constants and the S-curve half-period table for the ramp pulse generator.
`timescale 1ns / 1ps

package strpg_pkg;

  // Number of steps covered by the acceleration ramp
  localparam int unsigned RampSteps = 160;
  // Last entry of the S-curve table
  localparam int unsigned TableLast = 160;
  localparam int unsigned TableDepth = TableLast + 1;
  localparam int unsigned IdxW = $clog2(TableDepth);

  localparam int unsigned PosW = 32;
  localparam int unsigned HpW = 16;
  localparam int unsigned AccW = 8;

  // Half-period after reset (slowest entry)
  localparam logic [HpW-1:0] HalfPeriodReset = 16'd50288;

  // Item operation codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } op_e;

  // Input beat
  typedef struct packed {
    logic            operation;
    logic [PosW-1:0] target_position;
  } in_t;

  // Result beat
  typedef struct packed {
    logic            step_level;
    logic [PosW-1:0] position;
    logic            busy_res;
    logic            move_done;
    logic [HpW-1:0]  half_period;
  } out_t;

  // S-curve half-period table, fastest entry first
  localparam logic [HpW-1:0] RampTable [TableDepth] = '{
    16'd8504,  16'd8512,  16'd8521,  16'd8530,  16'd8540,  16'd8551,  16'd8563,  16'd8575,
    16'd8589,  16'd8603,  16'd8619,  16'd8636,  16'd8655,  16'd8674,  16'd8695,  16'd8718,
    16'd8743,  16'd8769,  16'd8798,  16'd8828,  16'd8861,  16'd8897,  16'd8935,  16'd8976,
    16'd9021,  16'd9068,  16'd9119,  16'd9174,  16'd9233,  16'd9297,  16'd9365,  16'd9438,
    16'd9517,  16'd9602,  16'd9692,  16'd9790,  16'd9894,  16'd10006, 16'd10126, 16'd10254,
    16'd10392, 16'd10539, 16'd10697, 16'd10865, 16'd11045, 16'd11237, 16'd11442, 16'd11660,
    16'd11893, 16'd12141, 16'd12405, 16'd12685, 16'd12982, 16'd13297, 16'd13631, 16'd13984,
    16'd14358, 16'd14752, 16'd15167, 16'd15603, 16'd16062, 16'd16543, 16'd17047, 16'd17573,
    16'd18122, 16'd18694, 16'd19287, 16'd19903, 16'd20540, 16'd21198, 16'd21874, 16'd22570,
    16'd23282, 16'd24011, 16'd24753, 16'd25508, 16'd26273, 16'd27047, 16'd27828, 16'd28613,
    16'd29400, 16'd30187, 16'd30972, 16'd31753, 16'd32527, 16'd33292, 16'd34047, 16'd34789,
    16'd35518, 16'd36230, 16'd36926, 16'd37602, 16'd38260, 16'd38897, 16'd39513, 16'd40106,
    16'd40678, 16'd41227, 16'd41753, 16'd42257, 16'd42738, 16'd43197, 16'd43633, 16'd44048,
    16'd44442, 16'd44816, 16'd45169, 16'd45503, 16'd45818, 16'd46115, 16'd46395, 16'd46659,
    16'd46907, 16'd47140, 16'd47358, 16'd47563, 16'd47755, 16'd47935, 16'd48103, 16'd48261,
    16'd48408, 16'd48546, 16'd48674, 16'd48794, 16'd48906, 16'd49010, 16'd49108, 16'd49198,
    16'd49283, 16'd49362, 16'd49435, 16'd49503, 16'd49567, 16'd49626, 16'd49681, 16'd49732,
    16'd49779, 16'd49824, 16'd49865, 16'd49903, 16'd49939, 16'd49972, 16'd50002, 16'd50031,
    16'd50057, 16'd50082, 16'd50105, 16'd50126, 16'd50145, 16'd50164, 16'd50181, 16'd50197,
    16'd50211, 16'd50225, 16'd50237, 16'd50249, 16'd50260, 16'd50270, 16'd50279, 16'd50288,
    16'd50288
  };

endpackage

@@ hw/rtl/stepper_table_ramp_pulse_generator_top.sv @@
// Top level of the stepper pulse generator with S-curve half-period ramp.
`timescale 1ns / 1ps

// Stepper pulse generator. Each input beat is either one timer tick or a move
// command that loads a new target; every beat returns exactly one result beat.
// The block takes one beat per clock cycle, sustained, as long as the result
// side keeps taking beats; a stalled result holds the decode stage and so
// stalls the input. A result is registered in the decode stage and then in
// the output register before it is offered. The half-period ROM is read
// synchronously in the decode stage. Its word goes into the half-period
// register on the edge where the decode stage hands its beat on. Until then
// the tick compare of the following beat sees it through a bypass.
// ramp_enable may only be written while idle.
module stepper_table_ramp_pulse_generator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  strpg_pkg::in_t      in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output strpg_pkg::out_t     out_data_o
);

  // Decode stage contents
  typedef struct packed {
    logic                          step_level;
    logic [strpg_pkg::PosW-1:0]    position;
    logic                          busy_res;
    logic                          move_done;
    logic                          hp_update;
  } s1_t;

  // Architectural state
  logic                          ramp_en_q;
  logic [strpg_pkg::HpW-1:0]     tick_q, tick_d;
  logic [strpg_pkg::HpW-1:0]     hp_q, hp_d;
  logic                          phase_q, phase_d;
  logic                          pulse_q, pulse_d;
  logic [strpg_pkg::PosW-1:0]    pos_q, pos_d;
  logic [strpg_pkg::PosW-1:0]    goal_q, goal_d;
  logic [strpg_pkg::AccW-1:0]    acc_q, acc_d;
  logic                          run_q, run_d;

  // Pipeline
  logic                          s1_valid_q, s1_valid_d;
  s1_t                           s1_q, s1_d;
  logic [strpg_pkg::HpW-1:0]     rom_q;
  logic                          out_valid_q, out_valid_d;
  strpg_pkg::out_t               out_q;

  logic                          accept;
  logic                          s1_adv;
  logic [strpg_pkg::HpW-1:0]     hp_fwd;
  logic [strpg_pkg::HpW-1:0]     hp_now;
  logic [strpg_pkg::HpW-1:0]     tick_inc;
  logic                          toggle;
  logic                          step;
  logic                          move_dn;
  logic                          move_up;
  logic                          arrive;
  logic [strpg_pkg::PosW-1:0]    remain;
  logic [strpg_pkg::PosW-1:0]    offset;
  logic [strpg_pkg::IdxW-1:0]    rom_idx;
  logic [strpg_pkg::PosW-1:0]    idx_wide;

  // Handshake and stage movement
  assign s1_adv      = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = s1_valid_q & ~s1_adv;
  assign accept      = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = accept | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & out_stall_i);

  // Half-period in force, bypassing a pending ROM word
  assign hp_fwd = (s1_valid_q & s1_q.hp_update) ? rom_q : hp_q;
  assign hp_now = s1_q.hp_update ? rom_q : hp_q;
  assign hp_d   = (s1_adv & s1_q.hp_update) ? rom_q : hp_q;

  // Tick, toggle and step decode
  always_comb begin
    tick_inc = tick_q + strpg_pkg::HpW'(1);
    toggle   = 1'b0;
    step     = 1'b0;
    tick_d   = tick_q;
    phase_d  = phase_q;
    pulse_d  = pulse_q;
    pos_d    = pos_q;
    goal_d   = goal_q;
    acc_d    = acc_q;
    run_d    = run_q;
    move_dn  = 1'b0;
    move_up  = 1'b0;
    arrive   = 1'b0;
    remain   = '0;
    offset   = '0;
    idx_wide = '0;
    rom_idx  = '0;

    if (accept) begin
      unique case (strpg_pkg::op_e'(in_data_i.operation))
        strpg_pkg::OP_MOVE: begin
          goal_d = in_data_i.target_position;
          run_d  = (pos_q != in_data_i.target_position);
        end
        strpg_pkg::OP_TICK: begin
          if (run_q) begin
            tick_d = tick_inc;
            toggle = (tick_inc >= hp_fwd);
          end
        end
        default: ;
      endcase
    end

    if (toggle) begin
      tick_d  = '0;
      pulse_d = ~pulse_q;
      phase_d = ~phase_q;
      step    = phase_q;
    end

    // One step toward the goal
    if (step) begin
      move_dn = (pos_q > goal_q);
      move_up = (pos_q < goal_q);
      if (move_dn) begin
        remain = pos_q - goal_q;
        pos_d  = pos_q - strpg_pkg::PosW'(1);
      end else if (move_up) begin
        remain = goal_q - pos_q;
        pos_d  = pos_q + strpg_pkg::PosW'(1);
      end
      if ((move_dn | move_up) && (acc_q < strpg_pkg::AccW'(strpg_pkg::RampSteps))) begin
        acc_d = acc_q + strpg_pkg::AccW'(1);
      end
      arrive = (pos_d == goal_q);
      if (arrive) begin
        remain = '0;
        acc_d  = '0;
        run_d  = 1'b0;
      end
    end

    // Table index from acceleration index or remaining distance
    offset = (remain > strpg_pkg::PosW'(strpg_pkg::RampSteps))
             ? strpg_pkg::PosW'(acc_d) : remain;
    idx_wide = (offset > strpg_pkg::PosW'(strpg_pkg::RampSteps))
               ? '0 : strpg_pkg::PosW'(strpg_pkg::RampSteps) - offset;
    rom_idx = (idx_wide > strpg_pkg::PosW'(strpg_pkg::TableLast))
              ? strpg_pkg::IdxW'(strpg_pkg::TableLast) : idx_wide[strpg_pkg::IdxW-1:0];
  end

  // Decode stage payload
  always_comb begin
    s1_d            = s1_q;
    s1_d.step_level = pulse_d;
    s1_d.position   = pos_d;
    s1_d.busy_res   = run_d;
    s1_d.move_done  = step & arrive;
    s1_d.hp_update  = step & ramp_en_q;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      ramp_en_q <= cfg_data_i;
    end
  end

  // State and pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      hp_q        <= strpg_pkg::HalfPeriodReset;
      phase_q     <= 1'b0;
      pulse_q     <= 1'b0;
      pos_q       <= '0;
      goal_q      <= '0;
      acc_q       <= '0;
      run_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tick_q      <= tick_d;
      hp_q        <= hp_d;
      phase_q     <= phase_d;
      pulse_q     <= pulse_d;
      pos_q       <= pos_d;
      goal_q      <= goal_d;
      acc_q       <= acc_d;
      run_q       <= run_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Decode stage register and synchronous ROM read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q  <= s1_d;
      rom_q <= strpg_pkg::RampTable[rom_idx];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.step_level  <= s1_q.step_level;
      out_q.position    <= s1_q.position;
      out_q.busy_res    <= s1_q.busy_res;
      out_q.move_done   <= s1_q.move_done;
      out_q.half_period <= hp_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
